FILE: design/assert_macros.svh
// Assertion macros shared by the syndrome calculator modules.
// Needs a clk and an active-low rst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset
`define RSSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define RSSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  `RSSC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: design/rssc_pkg.sv
// Package for the RS syndrome calculator: sizes, register codes,
// snapshot type and GF(2^m) helper functions. No dependencies.
package rssc_pkg;

  // Field and store sizes
  localparam int SYMBOL_BITS   = 8;
  localparam int MAX_SYNDROMES = 32;
  localparam int SYM_W         = SYMBOL_BITS;
  localparam int IDX_W         = (MAX_SYNDROMES > 1) ? $clog2(MAX_SYNDROMES) : 1;
  localparam int SETTLE_W      = IDX_W;

  // Port widths fixed by the interface
  localparam int IN_SYM_W    = 8;
  localparam int OUT_VAL_W   = 8;
  localparam int OUT_IDX_W   = 5;
  localparam int POLY_W      = 9;
  localparam int NUM_W       = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRIM_POLY     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SYNDROMES = 1'd1;

  // Reset values
  localparam logic [POLY_W-1:0] PRIM_POLY_RESET = 9'd285;
  localparam logic [NUM_W-1:0]  NUM_SYND_RESET  = 6'd16;

  // Cycles for the alpha power chain to settle after a polynomial change
  localparam logic [SETTLE_W-1:0] SETTLE_LOAD = SETTLE_W'(MAX_SYNDROMES - 1);

  // One finished codeword: all syndromes plus the index of the last one to send
  typedef struct packed {
    logic [MAX_SYNDROMES-1:0][SYM_W-1:0] synd;
    logic [IDX_W-1:0]                    last_idx;
  } snap_t;

  // Multiply by alpha (x) with reduction by the low bits of the polynomial
  function automatic logic [SYM_W-1:0] gf_xtime(input logic [SYM_W-1:0] v,
                                                input logic [SYM_W-1:0] poly);
    return {v[SYM_W-2:0], 1'b0} ^ (v[SYM_W-1] ? poly : '0);
  endfunction

  // General field multiply, shift-and-add over the bits of b
  function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                              input logic [SYM_W-1:0] b,
                                              input logic [SYM_W-1:0] poly);
    logic [SYM_W-1:0] acc;
    logic [SYM_W-1:0] sh;
    acc = '0;
    sh  = a;
    for (int k = 0; k < SYM_W; k++) begin
      if (b[k]) acc = acc ^ sh;
      sh = gf_xtime(sh, poly);
    end
    return acc;
  endfunction

endpackage

FILE: design/rssc_front.sv
// Front end: config registers, alpha power chain and the syndrome
// accumulators. Uses rssc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rssc_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rssc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rssc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rssc_pkg::IN_SYM_W-1:0]   in_symbol,
  input  logic                            in_last_symbol,
  output logic                            push_valid,
  output rssc_pkg::snap_t                 push_data,
  input  logic                            q_full
);
  import rssc_pkg::*;

  logic [POLY_W-1:0]   prim_poly_r;
  logic [NUM_W-1:0]    num_synd_r;
  logic [SETTLE_W-1:0] settle_r;
  logic [SYM_W-1:0]    poly;
  logic [SYM_W-1:0]    sym;
  logic [SYM_W-1:0]    pow_r  [MAX_SYNDROMES];
  logic [SYM_W-1:0]    synd_r [MAX_SYNDROMES];
  logic [SYM_W-1:0]    synd_nxt [MAX_SYNDROMES];
  logic [IDX_W-1:0]    last_idx;
  logic                accept;

  assign poly   = SYM_W'(prim_poly_r);
  assign sym    = SYM_W'(in_symbol);
  assign in_ready = (settle_r == '0) && !q_full;
  assign accept = in_valid && in_ready;

  // Config registers and settle counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prim_poly_r <= PRIM_POLY_RESET;
      num_synd_r  <= NUM_SYND_RESET;
      settle_r    <= SETTLE_LOAD;
    end else begin
      if (cfg_we && (cfg_index == REG_PRIM_POLY)) begin
        settle_r <= SETTLE_LOAD;
      end else if (settle_r != '0) begin
        settle_r <= settle_r - 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PRIM_POLY: prim_poly_r <= POLY_W'(cfg_wdata);
          REG_NUM_SYNDROMES: num_synd_r <= NUM_W'(cfg_wdata);
          default: ;
        endcase
      end
    end
  end

  // alpha^j chain: each stage is alpha times its neighbor
  always_ff @(posedge clk) begin
    pow_r[0] <= SYM_W'(1);
    for (int j = 1; j < MAX_SYNDROMES; j++) begin
      pow_r[j] <= gf_xtime(pow_r[j-1], poly);
    end
  end

  // Horner update, all syndromes in parallel
  always_comb begin
    for (int j = 0; j < MAX_SYNDROMES; j++) begin
      synd_nxt[j] = gf_mul(synd_r[j], pow_r[j], poly) ^ sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_SYNDROMES; j++) synd_r[j] <= '0;
    end else if (accept) begin
      for (int j = 0; j < MAX_SYNDROMES; j++) begin
        synd_r[j] <= in_last_symbol ? '0 : synd_nxt[j];
      end
    end
  end

  // Syndrome count, clamped to 1..MAX
  always_comb begin
    if (num_synd_r == '0) begin
      last_idx = '0;
    end else if (int'(num_synd_r) > MAX_SYNDROMES) begin
      last_idx = IDX_W'(MAX_SYNDROMES - 1);
    end else begin
      last_idx = IDX_W'(num_synd_r - 1'b1);
    end
  end

  // Snapshot handed to the queue on the last beat
  assign push_valid = accept && in_last_symbol;
  always_comb begin
    for (int j = 0; j < MAX_SYNDROMES; j++) push_data.synd[j] = synd_nxt[j];
    push_data.last_idx = last_idx;
  end

  `RSSC_ASSERT_NEXT(a_poly_write_stalls, cfg_we && (cfg_index == REG_PRIM_POLY),
    !in_ready, "input taken while alpha powers settle")
  `RSSC_ASSERT_NEXT(a_clear_after_last, accept && in_last_symbol,
    synd_r[0] == '0, "syndrome store not cleared after last symbol")

endmodule

FILE: design/rssc_queue.sv
// Two-entry queue of finished syndrome snapshots between front and back.
// Uses rssc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rssc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  rssc_pkg::snap_t push_data,
  output logic            q_full,
  output logic            q_valid,
  output rssc_pkg::snap_t q_head,
  input  logic            pop
);
  import rssc_pkg::*;

  snap_t       mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;

  assign q_full  = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_valid) mem_r[wr_ptr_r] <= push_data;
  end

  // Pointers and occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push_valid && !pop) cnt_nxt = cnt_r + 2'd1;
    if (pop && !push_valid) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_valid) wr_ptr_r <= ~wr_ptr_r;
      if (pop)        rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  `RSSC_ASSERT(a_no_overflow, push_valid |-> !q_full, "push into full queue")
  `RSSC_ASSERT(a_no_underflow, pop |-> q_valid, "pop from empty queue")

endmodule

FILE: design/rssc_back.sv
// Back end: walks the head snapshot and sends one syndrome per beat
// through the output register. Uses rssc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rssc_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  rssc_pkg::snap_t                q_head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rssc_pkg::OUT_VAL_W-1:0] out_syndrome_value,
  output logic [rssc_pkg::OUT_IDX_W-1:0] out_syndrome_index,
  output logic                           out_last_syndrome
);
  import rssc_pkg::*;

  logic                 out_valid_r;
  logic [OUT_VAL_W-1:0] value_r;
  logic [OUT_IDX_W-1:0] index_r;
  logic                 last_r;
  logic [IDX_W-1:0]     j_r;
  logic                 load;
  logic                 at_last;

  assign load    = !out_valid_r || out_ready;
  assign at_last = (j_r == q_head.last_idx);
  assign pop     = load && q_valid && at_last;

  // Control: output valid and syndrome index walker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      j_r         <= '0;
    end else if (load) begin
      out_valid_r <= q_valid;
      if (q_valid) j_r <= at_last ? '0 : j_r + 1'b1;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      value_r <= OUT_VAL_W'(q_head.synd[j_r]);
      index_r <= OUT_IDX_W'(j_r);
      last_r  <= at_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_syndrome_value = value_r;
  assign out_syndrome_index = index_r;
  assign out_last_syndrome  = last_r;

  `RSSC_ASSERT_NEXT(a_pop_marks_last, pop, out_valid_r && last_r,
    "entry released without final syndrome")

endmodule

FILE: design/rs_syndrome_calculator.sv
// RS syndrome calculator: one symbol per cycle, 32 parallel Horner updates.
// The last symbol's snapshot goes into the queue, then the output register;
// then one syndrome per cycle while out_ready is high; a codeword's results
// take num_syndromes beats (clamped to 1..32). Input stalls only when two
// finished codewords wait in the queue, or after reset and each prim_poly
// write while alpha powers settle. Sync reset (rst_n low) clears control state.
module rs_syndrome_calculator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rssc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rssc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rssc_pkg::IN_SYM_W-1:0]   in_symbol,
  input  logic                            in_last_symbol,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rssc_pkg::OUT_VAL_W-1:0]  out_syndrome_value,
  output logic [rssc_pkg::OUT_IDX_W-1:0]  out_syndrome_index,
  output logic                            out_last_syndrome
);
  import rssc_pkg::*;

  logic  push_valid;
  snap_t push_data;
  logic  q_full;
  logic  q_valid;
  snap_t q_head;
  logic  pop;

  // Symbol intake and accumulation
  rssc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_symbol      (in_symbol),
    .in_last_symbol (in_last_symbol),
    .push_valid     (push_valid),
    .push_data      (push_data),
    .q_full         (q_full)
  );

  // Snapshot queue
  rssc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop)
  );

  // Result serializer
  rssc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_head             (q_head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_syndrome_value (out_syndrome_value),
    .out_syndrome_index (out_syndrome_index),
    .out_last_syndrome  (out_last_syndrome)
  );

endmodule
